>>> rtl/glm_pkg.sv
// ----------------------------------------------------------------------------
// glm_pkg
// Shared types and constants for the L1 gradient magnitude block.
// ----------------------------------------------------------------------------
package glm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W  = 8;
    localparam int COL_W  = 10;
    localparam int ROW_W  = 12;
    localparam int CFGW_W = 11;   // image_width register
    localparam int CFGH_W = 13;   // image_height register
    localparam int CFG_W  = 13;   // widest register
    localparam int OUT_W  = 32;   // 30 bits of fields, padded to whole bytes

    localparam logic [CFGW_W-1:0] WIDTH_MIN   = CFGW_W'(3);
    localparam logic [CFGW_W-1:0] WIDTH_MAX   = CFGW_W'(MAX_WIDTH);
    localparam logic [CFGW_W-1:0] WIDTH_RST   = CFGW_W'(640);
    localparam logic [CFGH_W-1:0] HEIGHT_MIN  = CFGH_W'(3);
    localparam logic [CFGH_W-1:0] HEIGHT_MAX  = CFGH_W'(MAX_HEIGHT);
    localparam logic [CFGH_W-1:0] HEIGHT_RST  = CFGH_W'(480);
    localparam logic [PIX_W:0]    SAT_LIMIT   = (PIX_W+1)'(255);

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // pixel held between the line store read and the update
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } pix_stage_t;

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] d;
        begin
            if (a > b)
            begin
                d = a - b;
            end
            else
            begin
                d = b - a;
            end
            return d;
        end
    endfunction

endpackage

>>> rtl/gradient_l1_magnitude_top.sv
// ----------------------------------------------------------------------------
// gradient_l1_magnitude_top
// Central-difference L1 gradient magnitude over a raster pixel stream.
// ----------------------------------------------------------------------------
// result (r, c): m_tvalid rises once pixel (r+1, c+1) has passed stage 1 into the output register
// throughput: one pixel per clock, set by the single read and write port of
//   each line store; output stalls push back through a one-entry output register
// reset: counters to zero, width 640 and height 480; line stores and window
//   taps are not cleared and take no clearing pass
module gradient_l1_magnitude_top
    import glm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,     // [7:0] pixel
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,     // [7:0] magnitude, [19:8] out_row, [29:20] out_col
    input  logic             cfg_we,
    input  cfg_reg_t         cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata
);

    logic [CFGW_W-1:0] width_reg;
    logic [CFGH_W-1:0] height_reg;
    logic [CFGW_W-1:0] eff_width;
    logic [CFGH_W-1:0] eff_height;

    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;

    logic              s1_valid_reg;
    pix_stage_t        s1_reg;
    logic              s1_emit;
    logic              s1_adv;
    logic              in_accept;

    logic [PIX_W-1:0]  up1;
    logic [PIX_W-1:0]  up2;
    logic [PIX_W-1:0]  tap_reg [4];
    logic [PIX_W:0]    sum;
    logic [PIX_W-1:0]  mag_next;

    logic              out_valid_reg;
    logic [PIX_W-1:0]  mag_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[CFGW_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
            endcase
        end
    end

    always_comb
    begin
        priority if (width_reg < WIDTH_MIN)
            eff_width = WIDTH_MIN;
        else if (width_reg > WIDTH_MAX)
            eff_width = WIDTH_MAX;
        else
            eff_width = width_reg;

        priority if (height_reg < HEIGHT_MIN)
            eff_height = HEIGHT_MIN;
        else if (height_reg > HEIGHT_MAX)
            eff_height = HEIGHT_MAX;
        else
            eff_height = height_reg;
    end

    // handshake
    assign s1_emit   = (s1_reg.col >= COL_W'(2)) && (s1_reg.row >= ROW_W'(2));
    assign s1_adv    = s1_valid_reg && (!s1_emit || !out_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || s1_adv;
    assign in_accept = s_tvalid && s_tready;

    // raster position of the next pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            if ({1'b0, col_reg} + CFGW_W'(1) >= eff_width)
            begin
                col_reg <= '0;
                if ({1'b0, row_reg} + CFGH_W'(1) >= eff_height)
                begin
                    row_reg <= '0;
                end
                else
                begin
                    row_reg <= row_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // line stores: read at accept, written back when the pixel leaves stage 1
    glm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_above (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_reg.col),
        .wdata (s1_reg.pixel),
        .re    (in_accept),
        .raddr (col_reg),
        .rdata (up1)
    );

    glm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_two_above (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_reg.col),
        .wdata (up1),
        .re    (in_accept),
        .raddr (col_reg),
        .rdata (up2)
    );

    // stage 1: pixel waiting on its line store read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg.pixel <= s_tdata;
            s1_reg.col   <= col_reg;
            s1_reg.row   <= row_reg;
        end
    end

    // window taps: 0 current row, 1 and 2 row above, 3 two rows above
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            tap_reg[0] <= s1_reg.pixel;
            tap_reg[1] <= up1;
            tap_reg[2] <= tap_reg[1];
            tap_reg[3] <= up2;
        end
    end

    assign sum      = {1'b0, abs_diff(up1, tap_reg[2])} + {1'b0, abs_diff(tap_reg[0], tap_reg[3])};
    assign mag_next = (sum > SAT_LIMIT) ? SAT_LIMIT[PIX_W-1:0] : sum[PIX_W-1:0];

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_emit)
        begin
            mag_reg     <= mag_next;
            out_row_reg <= s1_reg.row - ROW_W'(1);
            out_col_reg <= s1_reg.col - COL_W'(1);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_W - PIX_W - ROW_W - COL_W)'(0), out_col_reg, out_row_reg, mag_reg};

    // a result moving out of stage 1 always lands in the output register
    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_emit |=> m_tvalid)
        else $error("result lost between stage 1 and output register");

    // a new read never hits the column being written back
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && s1_adv |-> col_reg != s1_reg.col)
        else $error("line store read and write at the same column");

    // interior positions only
    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_row_reg != '0 && out_col_reg != '0)
        else $error("result reported for a border pixel");

    // a pixel that gives no result never blocks the input
    a_border_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_emit |-> s_tready)
        else $error("border pixel stalled the input");

endmodule

>>> rtl/glm_ram.sv
// ----------------------------------------------------------------------------
// glm_ram
// Simple dual-port RAM, one write port and one read port with registered read.
// ----------------------------------------------------------------------------
module glm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read data holds while re is low
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> test/tb_gradient_l1_magnitude_top.sv
// ----------------------------------------------------------------------------
// tb_gradient_l1_magnitude_top
// Streams raster frames of grey pixels into the gradient block and checks
// every magnitude, row and column against an in-bench gradient predictor.
// A short table of tiny frames comes first, then just over one row at the largest
// width, then random frame shapes, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_gradient_l1_magnitude_top;
    import glm_pkg::*;

    localparam int ITEM_TARGET    = 1300;
    localparam int DRAIN_SLACK    = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TABLE_ROWS     = 27;

    typedef enum int {
        PIX_UNIFORM,
        PIX_EXTREME,
        PIX_SMOOTH
    } pix_mode_t;

    typedef struct {
        logic [PIX_W-1:0] mag;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } grad_t;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic             typed;
        logic [PIX_W-1:0] mag;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_we;
    cfg_reg_t         cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;

    // predictor copy of the block
    logic [CFGW_W-1:0] width_reg;
    logic [CFGH_W-1:0] height_reg;
    logic [PIX_W-1:0]  row_above_mem [MAX_WIDTH];
    logic [PIX_W-1:0]  row_two_up_mem [MAX_WIDTH];
    logic [PIX_W-1:0]  tap_cur_prev;
    logic [PIX_W-1:0]  tap_up_prev;
    logic [PIX_W-1:0]  tap_up_prev2;
    logic [PIX_W-1:0]  tap_two_up_prev;
    int                col_pos;
    int                row_pos;

    grad_t     expected_grad_q [$];
    grad_t     no_typed;
    stim_row_t stim_table [TABLE_ROWS];

    int err_count   = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    int gap_max     = 0;
    int sent_pixels = 0;
    int smooth_level = 128;

    gradient_l1_magnitude_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int eff_width();
        if (width_reg < WIDTH_MIN)
        begin
            return int'(WIDTH_MIN);
        end
        if (width_reg > WIDTH_MAX)
        begin
            return int'(WIDTH_MAX);
        end
        return int'(width_reg);
    endfunction

    function automatic int eff_height();
        if (height_reg < HEIGHT_MIN)
        begin
            return int'(HEIGHT_MIN);
        end
        if (height_reg > HEIGHT_MAX)
        begin
            return int'(HEIGHT_MAX);
        end
        return int'(height_reg);
    endfunction

    // advances the predictor by one pixel, returns 1 when a magnitude is due
    function automatic bit compute_gradient(input logic [PIX_W-1:0] px, output grad_t res);
        int w;
        int h;
        int up1;
        int up2;
        int dx;
        int dy;
        int sum;
        bit emit;
        w    = eff_width();
        h    = eff_height();
        up1  = int'(row_above_mem[col_pos]);
        up2  = int'(row_two_up_mem[col_pos]);
        emit = (col_pos >= 2) && (row_pos >= 2);
        res.mag = '0;
        res.row = '0;
        res.col = '0;
        if (emit)
        begin
            // right is the row-above tap, left the one two columns back
            dx  = (up1 > int'(tap_up_prev2)) ? up1 - int'(tap_up_prev2)
                                             : int'(tap_up_prev2) - up1;
            dy  = (tap_cur_prev > tap_two_up_prev) ? int'(tap_cur_prev - tap_two_up_prev)
                                                   : int'(tap_two_up_prev - tap_cur_prev);
            sum = dx + dy;
            if (sum > int'(SAT_LIMIT))
            begin
                sum = int'(SAT_LIMIT);
            end
            res.mag = PIX_W'(sum);
            res.row = ROW_W'(row_pos - 1);
            res.col = COL_W'(col_pos - 1);
        end
        tap_up_prev2    = tap_up_prev;
        tap_up_prev     = PIX_W'(up1);
        tap_two_up_prev = PIX_W'(up2);
        tap_cur_prev    = px;
        row_two_up_mem[col_pos] = PIX_W'(up1);
        row_above_mem[col_pos]  = px;
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
        return emit;
    endfunction

    function automatic logic [PIX_W-1:0] next_pixel(input pix_mode_t mode);
        case (mode)
            PIX_EXTREME:
            begin
                return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
            end
            PIX_SMOOTH:
            begin
                smooth_level = (smooth_level + $urandom_range(0, 12) - 6) & 8'hFF;
                return PIX_W'(smooth_level);
            end
            default:
            begin
                return PIX_W'($urandom);
            end
        endcase
    endfunction

    task automatic push_pixel(input logic [PIX_W-1:0] px, input bit use_typed,
                              input grad_t typed_val);
        grad_t pred;
        int gap;
        bit emitted;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do
            @(posedge clk);
        while (!s_tready);
        sent_pixels++;
        emitted = compute_gradient(px, pred);
        if (use_typed)
        begin
            expected_grad_q.push_back(typed_val);
        end
        else if (emitted)
        begin
            expected_grad_q.push_back(pred);
        end
    endtask

    // hold off the sender until every magnitude is out and the pipe is quiet
    task automatic wait_results_done();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_grad_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    task automatic set_dims(input logic [CFGW_W-1:0] w_val, input logic [CFGH_W-1:0] h_val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_IMAGE_WIDTH;
        // upper bits beyond the width register are junk and must be ignored
        cfg_wdata <= {2'($urandom), w_val};
        @(posedge clk);
        width_reg = w_val;
        @(negedge clk);
        cfg_addr  <= REG_IMAGE_HEIGHT;
        cfg_wdata <= h_val;
        @(posedge clk);
        height_reg = h_val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_pixels(input int count, input pix_mode_t mode);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 399) == 0)
            begin
                wait_results_done();
            end
            push_pixel(next_pixel(mode), 1'b0, no_typed);
        end
    endtask

    // output side stalls on a rotating pattern, reloaded now and then
    initial
    begin
        logic [15:0] stall_pat;
        int ticks;
        m_tready  = 1'b0;
        stall_pat = '1;
        ticks     = 0;
        forever
        begin
            @(negedge clk);
            if (ticks == 0)
            begin
                ticks = $urandom_range(20, 200);
                case ($urandom_range(0, 3))
                    0: stall_pat = '1;
                    1: stall_pat = 16'($urandom) | 16'h1;
                    2: stall_pat = 16'($urandom) & 16'($urandom) | 16'h1;
                    default: stall_pat = 16'($urandom) | 16'($urandom);
                endcase
                if (stall_pat == '0)
                begin
                    stall_pat = 16'h1;
                end
            end
            ticks--;
            m_tready  <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
        end
    end

    always @(posedge clk)
    begin
        grad_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_grad_q.size() == 0)
            begin
                $error("unexpected result transaction, tdata %h", m_tdata);
                err_count++;
            end
            else
            begin
                want = expected_grad_q.pop_front();
                if (m_tdata[7:0] !== want.mag)
                begin
                    $error("magnitude: expected %0d, actual %0d", want.mag, m_tdata[7:0]);
                    err_count++;
                end
                if (m_tdata[19:8] !== want.row)
                begin
                    $error("out_row: expected %0d, actual %0d", want.row, m_tdata[19:8]);
                    err_count++;
                end
                if (m_tdata[29:20] !== want.col)
                begin
                    $error("out_col: expected %0d, actual %0d", want.col, m_tdata[29:20]);
                    err_count++;
                end
                if (m_tdata[OUT_W-1:30] !== '0)
                begin
                    $error("padding: expected 0, actual %0d", m_tdata[OUT_W-1:30]);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("gradient_l1_magnitude_top test failed");
            $finish;
        end
    end

    initial
    begin
        grad_t row_want;
        logic [CFGW_W-1:0] wreg;
        logic [CFGH_W-1:0] hreg;
        int frame_len;
        int n;
        int pick;
        bit at_frame_start;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_IMAGE_WIDTH;
        cfg_wdata = '0;
        no_typed.mag = '0;
        no_typed.row = '0;
        no_typed.col = '0;

        width_reg       = WIDTH_RST;
        height_reg      = HEIGHT_RST;
        tap_cur_prev    = '0;
        tap_up_prev     = '0;
        tap_up_prev2    = '0;
        tap_two_up_prev = '0;
        col_pos         = 0;
        row_pos         = 0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            row_above_mem[i]  = '0;
            row_two_up_mem[i] = '0;
        end

        // three 3x3 frames, one interior pixel each at row 1, column 1
        stim_table = '{
            // sharp edge on both axes, saturates
            '{8'd0,   1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd0,   1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd0,   1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd0,   1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd77,  1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd255, 1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd255, 1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd255, 1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd255, 1'b1, 8'd255, 12'd1, 10'd1},
            // flat field gives zero
            '{8'd128, 1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd128, 1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd128, 1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd128, 1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd128, 1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd128, 1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd128, 1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd128, 1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd128, 1'b1, 8'd0,   12'd1, 10'd1},
            // falling gradients, left above right and above above below
            '{8'd9,   1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd200, 1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd9,   1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd130, 1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd50,  1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd30,  1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd1,   1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd100, 1'b0, 8'd0,   12'd0, 10'd0},
            '{8'd1,   1'b0, 8'd0,   12'd0, 10'd0}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // below-range values clamp to a 3x3 frame
        set_dims(CFGW_W'(0), CFGH_W'(2));
        for (int i = 0; i < TABLE_ROWS; i++)
        begin
            row_want.mag = stim_table[i].mag;
            row_want.row = stim_table[i].row;
            row_want.col = stim_table[i].col;
            push_pixel(stim_table[i].px, stim_table[i].typed, row_want);
        end

        // largest width from above-range values, one full row and past the wrap
        wait_results_done();
        gap_max = 3;
        set_dims('1, '1);
        run_pixels(MAX_WIDTH + 4, PIX_EXTREME);
        // narrow the frame mid-row, the column counter wraps to a new row
        wait_results_done();
        gap_max = 0;
        set_dims(CFGW_W'(3), CFGH_W'(0));
        run_pixels(60, PIX_SMOOTH);

        while (sent_pixels < ITEM_TARGET)
        begin
            at_frame_start = (row_pos == 0) && (col_pos == 0);
            wait_results_done();
            pick = $urandom_range(0, 19);
            if (pick < 2)
            begin
                wreg = CFGW_W'($urandom_range(0, 2));
            end
            else if (pick == 2)
            begin
                wreg = CFGW_W'($urandom_range(25, 80));
            end
            else
            begin
                wreg = CFGW_W'($urandom_range(3, 24));
            end
            // the width may only grow at a frame start, else unwritten columns get read
            if (!at_frame_start && int'(wreg) > eff_width())
            begin
                wreg = CFGW_W'($urandom_range(0, eff_width()));
            end
            pick = $urandom_range(0, 19);
            if (pick < 2)
            begin
                hreg = CFGH_W'($urandom_range(0, 2));
            end
            else if (pick == 2)
            begin
                hreg = CFGH_W'($urandom_range(11, 30));
            end
            else
            begin
                hreg = CFGH_W'($urandom_range(3, 10));
            end
            set_dims(wreg, hreg);
            case ($urandom_range(0, 2))
                0: gap_max = 0;
                1: gap_max = 3;
                default: gap_max = 12;
            endcase
            frame_len = eff_width() * eff_height();
            if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 2 * frame_len);
            end
            else
            begin
                n = $urandom_range(1, 3) * frame_len;
            end
            if (n > ITEM_TARGET - sent_pixels)
            begin
                n = ITEM_TARGET - sent_pixels;
            end
            run_pixels(n, pix_mode_t'($urandom_range(0, 2)));
        end

        wait_results_done();
        if (err_count == 0)
        begin
            $display("gradient_l1_magnitude_top test passed");
        end
        else
        begin
            $display("gradient_l1_magnitude_top test failed");
        end
        $finish;
    end

endmodule
